>>> rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_byte;   // store msg_byte at the fill position, count length
    logic pad_start;   // write 0x80 and zero the rest of the block
    logic clear_buf;   // zero the whole block buffer
    logic put_len;     // write the bit length into words 14 and 15
    logic init_work;   // copy hash state into working vars
    logic round;       // run one compression round
    logic fold;        // add working vars into hash state
    logic digest_reset; // back to initial hash, zero length and fill
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic       block_full;  // fill count is at 63 before this byte
    logic       pad_two;     // fill count >= 56: two blocks of padding
    logic       last_round;  // round counter at 63
  } dp_sts_t;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

>>> rtl/sha_datapath.sv
// ----------------------------------------------------------------------------
// sha_datapath
// Block buffer, schedule window, working vars, hash state and length.
// ----------------------------------------------------------------------------
module sha_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  sha_pkg::dp_cmd_t  cmd,
  input  logic [7:0]        msg_byte,
  input  logic [2:0]        rd_index,
  output sha_pkg::dp_sts_t  sts,
  output logic [31:0]       rd_word
);
  import sha_pkg::*;

  logic [31:0] buf_r [16];
  logic [31:0] win_r [16];
  logic [31:0] work_r [8];
  logic [31:0] hash_r [8];
  logic [63:0] len_r;
  logic [5:0]  fill_r;
  logic [5:0]  rnd_r;

  logic [31:0] w15, w2, sg0, sg1, wt, s1, ch, s0, maj, t1, t2;
  logic [3:0]  fill_word;
  logic [4:0]  fill_shift;

  assign fill_word  = fill_r[5:2];
  assign fill_shift = {2'(2'd3 - fill_r[1:0]), 3'b000};

  // round function, one round per cycle
  always_comb begin
    w15 = win_r[4'(rnd_r[3:0] + 4'd1)];
    w2  = win_r[4'(rnd_r[3:0] + 4'd14)];
    sg0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    sg1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    if (rnd_r < 6'd16) begin
      wt = buf_r[rnd_r[3:0]];
    end else begin
      wt = win_r[rnd_r[3:0]] + sg0 + win_r[4'(rnd_r[3:0] + 4'd9)] + sg1;
    end
    s1  = rotr(work_r[4], 6) ^ rotr(work_r[4], 11) ^ rotr(work_r[4], 25);
    ch  = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
    t1  = work_r[7] + s1 + ch + ROUND_K[rnd_r] + wt;
    s0  = rotr(work_r[0], 2) ^ rotr(work_r[0], 13) ^ rotr(work_r[0], 22);
    maj = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
    t2  = s0 + maj;
  end

  assign sts.block_full = (fill_r == 6'd63);
  assign sts.pad_two    = (fill_r >= 6'd56);
  assign sts.last_round = (rnd_r == 6'd63);
  assign rd_word        = hash_r[rd_index];

  // payload stores
  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      if (fill_r[1:0] == 2'd0) begin
        buf_r[fill_word] <= {24'd0, msg_byte} << fill_shift;
      end else begin
        buf_r[fill_word] <= buf_r[fill_word] | ({24'd0, msg_byte} << fill_shift);
      end
    end
    if (cmd.pad_start) begin
      for (int i = 0; i < 16; i++) begin
        if (4'(i) > fill_word) buf_r[i] <= '0;
      end
      if (fill_r[1:0] == 2'd0) begin
        buf_r[fill_word] <= 32'h80 << fill_shift;
      end else begin
        buf_r[fill_word] <= buf_r[fill_word] | (32'h80 << fill_shift);
      end
    end
    if (cmd.clear_buf) begin
      for (int i = 0; i < 16; i++) buf_r[i] <= '0;
    end
    if (cmd.put_len) begin
      buf_r[14] <= len_r[63:32];
      buf_r[15] <= len_r[31:0];
    end
    if (cmd.init_work) begin
      for (int i = 0; i < 8; i++) work_r[i] <= hash_r[i];
    end
    if (cmd.round) begin
      win_r[rnd_r[3:0]] <= wt;
      for (int i = 1; i < 8; i++) work_r[i] <= work_r[i-1];
      work_r[4] <= work_r[3] + t1;
      work_r[0] <= t1 + t2;
    end
  end

  // control-side state: hash, length, fill and round counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) hash_r[i] <= H_INIT[i];
      len_r  <= '0;
      fill_r <= '0;
      rnd_r  <= '0;
    end else begin
      if (cmd.load_byte) begin
        len_r  <= len_r + 64'd8;
        fill_r <= fill_r + 6'd1;
      end
      if (cmd.init_work) rnd_r <= '0;
      else if (cmd.round) rnd_r <= rnd_r + 6'd1;
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) hash_r[i] <= hash_r[i] + work_r[i];
      end
      if (cmd.digest_reset) begin
        for (int i = 0; i < 8; i++) hash_r[i] <= H_INIT[i];
        len_r  <= '0;
        fill_r <= '0;
      end
    end
  end

endmodule

>>> rtl/sha_ctrl.sv
// ----------------------------------------------------------------------------
// sha_ctrl
// Sequencer: byte intake, padding, compression passes and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              byte_valid,
  input  logic              end_of_message,
  input  sha_pkg::dp_sts_t  sts,
  output sha_pkg::dp_cmd_t  cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        rd_index
);
  import sha_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_INIT  = 8'b0000_0010,
    S_ROUND = 8'b0000_0100,
    S_FOLD  = 8'b0000_1000,
    S_PAD   = 8'b0001_0000,
    S_LEN   = 8'b0010_0000,
    S_OUT   = 8'b0100_0000,
    S_CLR   = 8'b1000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic       eom_r, eom_nxt;      // message end pending
  logic       final_r, final_nxt;  // this compression is the last one
  logic [2:0] idx_r, idx_nxt;
  logic       padded_r, padded_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign rd_index  = idx_r;

  always_comb begin
    state_nxt = state_r;
    eom_nxt   = eom_r;
    final_nxt = final_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_byte = byte_valid;
          eom_nxt       = end_of_message;
          final_nxt     = 1'b0;
          if (byte_valid && sts.block_full) state_nxt = S_INIT;
          else if (end_of_message) state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        cmd.pad_start = 1'b1;
        eom_nxt       = 1'b0;
        if (sts.pad_two) begin
          state_nxt = S_INIT;
        end else begin
          state_nxt = S_LEN;
        end
      end
      S_CLR: begin
        cmd.clear_buf = 1'b1;
        state_nxt     = S_LEN;
      end
      S_LEN: begin
        cmd.put_len = 1'b1;
        final_nxt   = 1'b1;
        state_nxt   = S_INIT;
      end
      S_INIT: begin
        cmd.init_work = 1'b1;
        state_nxt     = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (sts.last_round) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (final_r) begin
          idx_nxt   = '0;
          state_nxt = S_OUT;
        end else if (eom_r) begin
          state_nxt = S_PAD;
        end else if (padded_r) begin
          state_nxt = S_CLR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            cmd.digest_reset = 1'b1;
            state_nxt        = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // remembers that padding ran with two blocks, so the second is cleared and holds only the length
  always_comb begin
    padded_nxt = padded_r;
    if (state_r == S_PAD) padded_nxt = sts.pad_two;
    else if (state_r == S_CLR || state_r == S_IDLE) padded_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      eom_r    <= 1'b0;
      final_r  <= 1'b0;
      idx_r    <= '0;
      padded_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      eom_r    <= eom_nxt;
      final_r  <= final_nxt;
      idx_r    <= idx_nxt;
      padded_r <= padded_nxt;
    end
  end

endmodule

>>> rtl/sha256_message_hasher.sv
// ----------------------------------------------------------------------------
// sha256_message_hasher
// SHA-256 over a byte stream, eight digest words per message.
// ----------------------------------------------------------------------------
// A byte word is taken while the hasher is idle; the 64th byte of a block
// starts the compression (one round a cycle in the shared round unit, plus
// load and fold). End of message adds padding and one or two compressions,
// then eight digest words, one per accepted output handshake. Hash state
// and length return to initial values after the eighth word.
module sha256_message_hasher (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sha_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sha_pkg::out_item_t  out_data
);
  import sha_pkg::*;

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [2:0]  rd_index;
  logic [31:0] rd_word;

  sha_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready,
    .byte_valid(in_data.byte_valid), .end_of_message(in_data.end_of_message),
    .sts, .cmd, .out_valid, .out_ready, .rd_index);

  sha_datapath u_dp (
    .clk, .rst_n, .cmd, .msg_byte(in_data.msg_byte), .rd_index,
    .sts, .rd_word);

  assign out_data.digest_word = rd_word;
  assign out_data.word_index  = rd_index;
  assign out_data.last_word   = (rd_index == 3'd7);

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Byte-stream SHA-256 check: messages of random length are fed a word at a
// time, digests are predicted in the bench and compared word by word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import sha_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // Idling mode: 0 none, 1 sender, 2 receiver, 3 both
  int        idle_mode = 0;
  bit        hold_sender = 1'b0;
  int        error_count = 0;
  int        quiet_cycles = 0;

  in_item_t  pending_words[$];
  out_item_t expected_digest[$];

  // Predictor state
  logic [31:0] hash_h [8];
  logic [31:0] blk [16];
  logic [63:0] bit_len;
  logic [5:0]  fill;

  sha256_message_hasher DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #1 clk = ~clk;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One 64-round compression of blk into hash_h
  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int t = 0; t < 64; t++) begin
      if (t < 16) w[t] = blk[t];
      else w[t] = w[t-16] + w[t-7]
          + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3))
          + (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10));
    end
    {a, b, c, d, e, f, g, h} = {hash_h[0], hash_h[1], hash_h[2], hash_h[3],
                                hash_h[4], hash_h[5], hash_h[6], hash_h[7]};
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[t] + w[t];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
    hash_h[4] += e; hash_h[5] += f; hash_h[6] += g; hash_h[7] += h;
  endtask

  task automatic put_byte(input logic [5:0] pos, input logic [7:0] value);
    int shift;
    shift = (3 - pos[1:0]) * 8;
    if (pos[1:0] == 2'd0) blk[pos[5:2]] = 32'(value) << shift;
    else blk[pos[5:2]] |= 32'(value) << shift;
  endtask

  task automatic hasher_reset();
    for (int i = 0; i < 8; i++) hash_h[i] = H_INIT[i];
    bit_len = '0;
    fill = '0;
  endtask

  // Advance the digest predictor by one accepted word
  task automatic predict_digest(input in_item_t word);
    out_item_t res;
    if (word.byte_valid) begin
      put_byte(fill, word.msg_byte);
      bit_len += 64'd8;
      fill += 6'd1;
      if (fill == 6'd0) compress();
    end
    if (!word.end_of_message) return;
    put_byte(fill, 8'h80);
    for (int i = fill[5:2] + 1; i < 16; i++) blk[i] = '0;
    if (fill >= 6'd56) begin
      compress();
      for (int i = 0; i < 16; i++) blk[i] = '0;
    end
    blk[14] = bit_len[63:32];
    blk[15] = bit_len[31:0];
    compress();
    for (int i = 0; i < 8; i++) begin
      res.digest_word = hash_h[i];
      res.word_index = 3'(i);
      res.last_word = (i == 7);
      expected_digest.push_back(res);
    end
    hasher_reset();
  endtask

  function automatic in_item_t make_word(input logic [7:0] b, input bit v, input bit e);
    in_item_t w;
    w.msg_byte = b;
    w.byte_valid = v;
    w.end_of_message = e;
    return w;
  endfunction

  // Queue a message of len bytes; last byte may carry the end flag
  task automatic queue_message(input int len, input bit end_on_byte, input bit noise);
    for (int i = 0; i < len; i++) begin
      if (noise && $urandom_range(0, 9) == 0)
        pending_words.push_back(make_word(8'($urandom), 1'b0, 1'b0));
      pending_words.push_back(make_word(8'($urandom), 1'b1,
                                        end_on_byte && (i == len - 1)));
    end
    if (!(end_on_byte && len > 0))
      pending_words.push_back(make_word(8'($urandom), 1'b0, 1'b1));
  endtask

  task automatic drain_wait();
    while (pending_words.size() != 0 || in_valid || expected_digest.size() != 0)
      @(posedge clk);
  endtask

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_words.size() != 0 && !hold_sender &&
          !((idle_mode == 1 && $urandom_range(0, 99) < 47) ||
            (idle_mode == 3 && $urandom_range(0, 99) < 21))) begin
        in_data <= pending_words.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !((idle_mode == 2 && $urandom_range(0, 99) < 47) ||
                        (idle_mode == 3 && $urandom_range(0, 99) < 21));
  end

  // Monitor, predictor and watchdog
  always @(posedge clk) begin
    out_item_t exp_word;
    if (rst_n) begin
      if (in_valid && in_ready) predict_digest(in_data);
      if (out_valid && out_ready) begin
        if (expected_digest.size() == 0) begin
          $display("%0t: unexpected digest word %h", $time, out_data);
          error_count++;
        end else begin
          exp_word = expected_digest.pop_front();
          if (out_data !== exp_word) begin
            $display("%0t: digest mismatch expected %h/%0d/%0d actual %h/%0d/%0d", $time,
                     exp_word.digest_word, exp_word.word_index, exp_word.last_word,
                     out_data.digest_word, out_data.word_index, out_data.last_word);
            error_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("sha256_message_hasher verification failed");
        $finish;
      end
    end
  end

  initial begin
    int lens [4];
    hasher_reset();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty message, byte with end flag, padding boundaries
    queue_message(0, 1'b0, 1'b0);
    pending_words.push_back(make_word(8'h00, 1'b1, 1'b1));
    pending_words.push_back(make_word(8'hff, 1'b1, 1'b1));
    queue_message(3, 1'b0, 1'b0);
    drain_wait();
    hold_sender = 1'b1;
    repeat (300) @(posedge clk);
    hold_sender = 1'b0;
    lens = '{55, 56, 64, 1};
    foreach (lens[i]) queue_message(lens[i], 1'(i % 2), 1'b0);
    drain_wait();

    // Random phases across idling modes
    for (int phase = 0; phase < 4; phase++) begin
      idle_mode = phase;
      for (int m = 0; m < 6; m++) begin
        queue_message($urandom_range(0, 4), 1'($urandom), 1'b1);
      end
      drain_wait();
    end
    idle_mode = 0;
    repeat (300) @(posedge clk);
    if (error_count == 0 && expected_digest.size() == 0)
      $display("sha256_message_hasher verification clean");
    else
      $display("sha256_message_hasher verification failed");
    $finish;
  end

endmodule
